### design/ulbp_pkg.sv
// Package for the uniform LBP label filter: widths, defaults, register
// indexes and the code-to-label lookup table. No dependencies.
package ulbp_pkg;

    localparam int PIXEL_W      = 8;
    localparam int LABEL_W      = 6;
    localparam int TDATA_OUT_W  = 8;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 11;
    localparam int HEIGHT_W     = 13;
    localparam int ROW_W        = 12;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int MIN_SIZE       = 3;
    localparam int DEF_WIDTH      = 128;
    localparam int DEF_HEIGHT     = 128;
    localparam int NUM_UNIFORM    = 58;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam int CODE_COUNT = 256;
    localparam int LUT_BITS   = CODE_COUNT * LABEL_W;

    // Uniform codes (at most two circular 0/1 transitions) are ranked in
    // ascending code order starting at 1; everything else maps to 0.
    function automatic logic [LUT_BITS-1:0] build_label_lut();
        logic [LUT_BITS-1:0] lut;
        logic [7:0]          code;
        logic [7:0]          rot;
        int                  rank;
        lut  = '0;
        rank = 0;
        for (int v = 0; v < CODE_COUNT; v++) begin
            code = 8'(v);
            rot  = {code[6:0], code[7]};
            if ($countones(code ^ rot) <= 2) begin
                rank = rank + 1;
                lut[v*LABEL_W +: LABEL_W] = LABEL_W'(rank);
            end
        end
        return lut;
    endfunction

    localparam logic [LUT_BITS-1:0] LABEL_LUT = build_label_lut();

    function automatic logic [LABEL_W-1:0] label_of(input logic [7:0] code);
        return LABEL_LUT[code*LABEL_W +: LABEL_W];
    endfunction

endpackage

### design/ulbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module ulbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/uniform_lbp_label_filter_core.sv
// Top level of the uniform LBP label filter: counters, line store, 3x3
// window and label output register. Uses ulbp_pkg and ulbp_ram.
//
// Usage:
//  - s_ channel: one 8-bit grey pixel per transfer, raster order.
//  - m_ channel: one 6-bit label per interior pixel (rows >= 2 and
//    columns >= 2 of the frame); m_tlast marks the last label of a frame.
//    Border pixels only fill the line store and produce no transfer.
//  - cfg port: cfg_wr_en/cfg_addr/cfg_wdata write image_width (index 0)
//    or image_height (index 1). Values are clamped to the legal range and
//    the frame restarts at row 0, column 0. Write only while idle.
//  - Output order: the label for pixel (r,c) appears on m_tdata after
//    pixel (r+1,c+1) is transferred in (the transfer loads stage A and the
//    line-store read; the output register loads when stage A advances).
//  - Throughput: one pixel per clock unless stalled, set by the line store
//    (one read port: a read and a write per cycle, at different columns).
//  - Stall: if the output register is full and m_tready is low, the pipe
//    freezes; s_tready drops once stage A also holds a pixel. Nothing is
//    lost or repeated.
//  - Reset (aresetn low, synchronous): counters, window and valid flags
//    clear; width/height return to 128. Line store contents are not reset.
module uniform_lbp_label_filter_core #(
    parameter int MAX_WIDTH = ulbp_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [ulbp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ulbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ulbp_pkg::PIXEL_W-1:0]    s_tdata,   // [7:0] pixel
    // label output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ulbp_pkg::TDATA_OUT_W-1:0] m_tdata,  // [5:0] label, [7:6] zero
    output logic                            m_tlast    // frame_end
);
    import ulbp_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int RESET_WIDTH = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;
    localparam int WORD_W = 2 * PIXEL_W;

    // ---------------- configuration ----------------
    logic [WID_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [31:0]         cfg_w32;
    logic [31:0]         cfg_h32;
    logic [WID_W-1:0]    width_clamped;
    logic [HEIGHT_W-1:0] height_clamped;

    assign cfg_w32 = 32'(cfg_wdata[CFG_WIDTH_W-1:0]);
    assign cfg_h32 = 32'(cfg_wdata[HEIGHT_W-1:0]);

    always_comb begin
        priority if (cfg_w32 < 32'(MIN_SIZE)) begin
            width_clamped = WID_W'(MIN_SIZE);
        end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
            width_clamped = WID_W'(MAX_WIDTH);
        end else begin
            width_clamped = WID_W'(cfg_w32);
        end
        priority if (cfg_h32 < 32'(MIN_SIZE)) begin
            height_clamped = HEIGHT_W'(MIN_SIZE);
        end else if (cfg_h32 > 32'(MAX_HEIGHT)) begin
            height_clamped = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            height_clamped = HEIGHT_W'(cfg_h32);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WID_W'(RESET_WIDTH);
            height_reg <= HEIGHT_W'(DEF_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH:  width_reg  <= width_clamped;
                REG_IMAGE_HEIGHT: height_reg <= height_clamped;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic advance;      // stage A may move into the output register
    logic accept;       // input transfer this cycle
    logic a_valid_reg;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // ---------------- raster counters ----------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             last_col;
    logic             last_row;

    assign last_col = (WID_W'(col_reg) == width_reg - WID_W'(1));
    assign last_row = (HEIGHT_W'(row_reg) == height_reg - HEIGHT_W'(1));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage A: line store read ----------------
    logic [PIXEL_W-1:0] a_pixel_reg;
    logic [COL_W-1:0]   a_col_reg;
    logic               a_interior_reg;
    logic               a_frame_end_reg;
    logic               a_valid_next;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (advance) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
        if (accept) begin
            a_pixel_reg     <= s_tdata;
            a_col_reg       <= col_reg;
            a_interior_reg  <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            a_frame_end_reg <= last_row && last_col;
        end
    end

    // Each word holds the two previous rows at one column: [7:0] top, [15:8] mid.
    logic              ram_we;
    logic [WORD_W-1:0] ram_rd_data;
    logic [PIXEL_W-1:0] top_px;
    logic [PIXEL_W-1:0] mid_px;

    assign top_px = ram_rd_data[PIXEL_W-1:0];
    assign mid_px = ram_rd_data[WORD_W-1:PIXEL_W];
    assign ram_we = a_valid_reg && advance;

    ulbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (a_col_reg),
        .wr_data ({a_pixel_reg, mid_px}),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // ---------------- 3x3 window ----------------
    // win[0..2]: column c-2 (top, mid, bottom); win[3..5]: column c-1.
    logic [PIXEL_W-1:0] win_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (ram_we) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_px;
            win_reg[4] <= mid_px;
            win_reg[5] <= a_pixel_reg;
        end
    end

    // LBP code: centre is win[4]; bit set when centre >= neighbour.
    logic [7:0] lbp_code;
    always_comb begin
        lbp_code[0] = win_reg[4] >= win_reg[0];
        lbp_code[1] = win_reg[4] >= win_reg[3];
        lbp_code[2] = win_reg[4] >= top_px;
        lbp_code[3] = win_reg[4] >= win_reg[1];
        lbp_code[4] = win_reg[4] >= mid_px;
        lbp_code[5] = win_reg[4] >= win_reg[2];
        lbp_code[6] = win_reg[4] >= win_reg[5];
        lbp_code[7] = win_reg[4] >= a_pixel_reg;
    end

    // ---------------- output register ----------------
    logic [LABEL_W-1:0] label_reg;
    logic               last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= a_valid_reg && a_interior_reg;
        end
        if (advance) begin
            label_reg <= label_of(lbp_code);
            last_reg  <= a_frame_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(label_reg);
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    a_label_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (label_reg <= LABEL_W'(NUM_UNIFORM)))
        else $error("label out of range");

    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (WID_W'(col_reg) < width_reg))
        else $error("column counter beyond image width");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (HEIGHT_W'(row_reg) < height_reg))
        else $error("row counter beyond image height");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && accept) |-> (a_col_reg != col_reg))
        else $error("line store read and write hit the same column");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && a_valid_reg))
        else $error("input stalled without output backpressure");
`endif

endmodule

### sim/tb_uniform_lbp_label_filter_core.sv
// Self-checking testbench for uniform_lbp_label_filter_core: streams pixels with random
// gaps and back-pressure and checks every label against an in-bench predictor.
// Depends on design/ulbp_pkg.sv and the core RTL only.
`timescale 1ns / 1ps

module tb_uniform_lbp_label_filter_core;
    import ulbp_pkg::*;

    localparam int SETTLE_CYC = 8;          // pipe is 2 deep; margin before cfg writes / end
    localparam int RAND_PIX   = 1100;       // random pixel budget
    localparam int RAND_CAP   = 300;        // most pixels in one random phase
    localparam int DRAIN_EVERY = 397;       // sender holds off until drained this often
    localparam int MAX_PRINT  = 100;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               frame_end;
    } lbp_result_t;

    // pixel content styles for a phase
    typedef enum int {PIX_NOISE, PIX_TIES, PIX_RAMP, PIX_EXTREME} pix_mode_t;

    // 3x3 directed frames, back to back at width 3 / height 3 (frame wrap included):
    // flat 255 (all ties, code 255), dark centre in a bright ring (code 0),
    // alternating ring around centre 100 (code 0x55, non-uniform).
    localparam logic [7:0] DIRECTED_PIX [27] = '{
        8'd255, 8'd255, 8'd255,  8'd255, 8'd255, 8'd255,  8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255,  8'd255, 8'd0,   8'd255,  8'd255, 8'd255, 8'd255,
        8'd50,  8'd200, 8'd50,   8'd200, 8'd100, 8'd50,   8'd200, 8'd50,  8'd200
    };

    // DUT ports; every input starts known
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [PIXEL_W-1:0]      s_tdata   = '0;   // [7:0] pixel
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_tdata;          // [5:0] label, [7:6] zero
    logic                    m_tlast;          // frame_end

    uniform_lbp_label_filter_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor state: two line stores, six-entry window, raster counters
    // and the effective (clamped) frame size.
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] older_line [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIXEL_W-1:0] newer_line [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIXEL_W-1:0] win_col [6] = '{default: '0};
    int unsigned        cur_col = 0;
    int unsigned        cur_row = 0;
    int unsigned        img_w   = DEF_WIDTH;
    int unsigned        img_h   = DEF_HEIGHT;
    logic [LABEL_W-1:0] uniform_rank [256];     // code -> label, built at time 0

    logic [PIXEL_W-1:0] pixel_q [$];            // pixels waiting to be sent
    lbp_result_t        label_exp_q [$];        // labels the core still owes us

    int unsigned        err_count    = 0;
    int unsigned        pixels_sent  = 0;
    int unsigned        labels_rcvd  = 0;
    int unsigned        frame_ends   = 0;
    int unsigned        cfg_writes   = 0;
    bit [NUM_UNIFORM:0] label_hit    = '0;
    bit                 send_no_idle = 1'b0;
    bit                 recv_no_idle = 1'b0;

    task automatic flag_mismatch(input string msg);
        if (err_count < MAX_PRINT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Per-transfer random wait; occasionally flips into or out of a
    // no-idle stretch so bursts at full rate also happen.
    function automatic int unsigned pick_wait(inout bit no_idle);
        if ($urandom_range(0, 39) == 0)
            no_idle = !no_idle;
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    // One accepted pixel: update stores, maybe queue a label, advance counters.
    task automatic predict_pixel(input logic [PIXEL_W-1:0] px);
        logic [PIXEL_W-1:0] up;
        logic [PIXEL_W-1:0] mid;
        logic [PIXEL_W-1:0] ctr;
        logic [7:0]         code;
        lbp_result_t        res;
        up  = older_line[cur_col];
        mid = newer_line[cur_col];
        older_line[cur_col] = mid;
        newer_line[cur_col] = px;
        if (cur_row >= 2 && cur_col >= 2) begin
            // centre is the middle row one column back; bit set when centre >= neighbour
            ctr  = win_col[4];
            code = {ctr >= px,  ctr >= win_col[5], ctr >= win_col[2], ctr >= mid,
                    ctr >= win_col[1], ctr >= up,  ctr >= win_col[3], ctr >= win_col[0]};
            res.label     = uniform_rank[code];
            res.frame_end = (cur_row + 1 >= img_h) && (cur_col + 1 >= img_w);
            label_exp_q   = {label_exp_q, res};
        end
        win_col[0] = win_col[3];
        win_col[1] = win_col[4];
        win_col[2] = win_col[5];
        win_col[3] = up;
        win_col[4] = mid;
        win_col[5] = px;
        if (cur_col + 1 >= img_w) begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= img_h) ? 0 : cur_row + 1;
        end else begin
            cur_col++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: presents queued pixels with random gaps. Every DRAIN_EVERY
    // transfers it holds off until all owed labels have come back.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : pixel_driver
        int unsigned gap_left;
        bit          draining;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left = 0;
            draining = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixel(s_tdata);
                pixels_sent++;
                if (pixels_sent % DRAIN_EVERY == 0)
                    draining = 1'b1;
            end
            // a pixel still waiting for s_tready stays on the bus untouched
            if (!(s_tvalid && !s_tready)) begin
                if (draining && label_exp_q.size() == 0)
                    draining = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (!draining && pixel_q.size() != 0) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left = pick_wait(send_no_idle);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each label transfer against the oldest expectation,
    // then stalls m_tready for a random number of cycles.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : label_monitor
        int unsigned stall_left;
        lbp_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                labels_rcvd++;
                if (label_exp_q.size() == 0) begin
                    flag_mismatch($sformatf("label transfer with none owed: tdata=%h tlast=%b",
                                            m_tdata, m_tlast));
                end else begin
                    want = label_exp_q.pop_front();
                    if (m_tdata !== TDATA_OUT_W'(want.label))
                        flag_mismatch($sformatf("label: got tdata=%h, want %0d",
                                                m_tdata, want.label));
                    else
                        label_hit[want.label] = 1'b1;
                    if (m_tlast !== want.frame_end)
                        flag_mismatch($sformatf("frame_end: got %b, want %b (label %0d)",
                                                m_tlast, want.frame_end, want.label));
                    if (want.frame_end)
                        frame_ends++;
                end
                stall_left = pick_wait(recv_no_idle);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    // Register write while idle; the predictor restarts its frame at once.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        int unsigned v;
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) begin
            v     = 32'(val[CFG_WIDTH_W-1:0]);
            img_w = (v < MIN_SIZE) ? MIN_SIZE : (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
        end else begin
            v     = 32'(val);
            img_h = (v < MIN_SIZE) ? MIN_SIZE : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
        end
        cur_col = 0;
        cur_row = 0;
        cfg_writes++;
    endtask

    // Sampled on the falling edge so the check never races the sender.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pixel_q.size() != 0 || s_tvalid || label_exp_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic logic [PIXEL_W-1:0] gen_pixel(input pix_mode_t mode,
                                                     input int unsigned idx,
                                                     input logic [PIXEL_W-1:0] base);
        int unsigned c;
        int unsigned r;
        c = idx % img_w;
        r = idx / img_w;
        case (mode)
            PIX_TIES:    return (base == 8'hFF) ? PIXEL_W'(base - $urandom_range(0, 1))
                                                : PIXEL_W'(base + $urandom_range(0, 1));
            PIX_RAMP:    return PIXEL_W'(base + r * 3 + c * 5 + $urandom_range(0, 2));
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:     return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixels(input pix_mode_t mode, input int unsigned count);
        logic [PIXEL_W-1:0] base;
        base = PIXEL_W'($urandom_range(0, 255));
        @(negedge aclk);
        for (int unsigned i = 0; i < count; i++)
            pixel_q = {pixel_q, gen_pixel(mode, i, base)};
    endtask

    initial begin : stimulus
        int unsigned rank;
        int unsigned flips;
        int unsigned rand_sent;
        int unsigned frame_pix;
        int unsigned count;
        int unsigned pick;

        // uniform codes: at most two circular bit changes, ranked in code order
        rank = 0;
        for (int v = 0; v < 256; v++) begin
            flips = 0;
            for (int b = 0; b < 8; b++)
                if (v[b] != v[(b + 1) % 8])
                    flips++;
            if (flips <= 2) begin
                rank++;
                uniform_rank[v] = LABEL_W'(rank);
            end else begin
                uniform_rank[v] = '0;
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size (128 x 128): two fill rows, then part of row 2
        push_pixels(PIX_NOISE, 2 * DEF_WIDTH + 40);
        wait_idle();

        // smallest frame, directed corner patterns, three frames back to back
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        @(negedge aclk);
        foreach (DIRECTED_PIX[i])
            pixel_q = {pixel_q, DIRECTED_PIX[i]};
        wait_idle();

        // 2047 clamps to the widest row; a short run stays inside the fill rows
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2047));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        push_pixels(PIX_RAMP, 50);
        wait_idle();

        // width 0 clamps up, all-ones height clamps to max: tall, no frame end
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
        write_reg(REG_IMAGE_HEIGHT, {CFG_DATA_W{1'b1}});
        push_pixels(PIX_EXTREME, 60);
        wait_idle();

        // bits above the width field are dropped (width 5); height 0 clamps up
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(13'h1805));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(0));
        push_pixels(PIX_TIES, 40);
        wait_idle();

        // below the minimum on both registers (height 2, width 1)
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
        push_pixels(PIX_NOISE, 30);
        wait_idle();

        // random phases: mostly small frames, whole frames plus a partial tail;
        // some phases write one register only, some continue without a restart
        rand_sent = 0;
        while (rand_sent < RAND_PIX) begin
            pick = $urandom_range(0, 4);
            if (pick != 1 && pick != 4)
                write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 4) == 0) ?
                          CFG_DATA_W'($urandom_range(13, 64)) :
                          CFG_DATA_W'($urandom_range(3, 12)));
            if (pick != 0 && pick != 4)
                write_reg(REG_IMAGE_HEIGHT, ($urandom_range(0, 4) == 0) ?
                          CFG_DATA_W'($urandom_range(9, 20)) :
                          CFG_DATA_W'($urandom_range(3, 8)));
            frame_pix = img_w * img_h;
            count = frame_pix * $urandom_range(1, 2) + $urandom_range(0, frame_pix - 1);
            if (count > RAND_CAP)
                count = RAND_CAP;
            push_pixels(pix_mode_t'($urandom_range(0, 3)), count);
            rand_sent += count;
            wait_idle();
        end

        if (label_exp_q.size() != 0)
            flag_mismatch($sformatf("%0d labels never arrived", label_exp_q.size()));

        $display("Run covered %0d pixel transfers, %0d label transfers, %0d frame ends,",
                 pixels_sent, labels_rcvd, frame_ends);
        $display("%0d register writes and %0d of %0d label values.",
                 cfg_writes, $countones(label_hit), NUM_UNIFORM + 1);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hang guard: several times the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
design/ulbp_pkg.sv
design/ulbp_ram.sv
design/uniform_lbp_label_filter_core.sv
sim/tb_uniform_lbp_label_filter_core.sv
